@@ rtl/plbp_pkg.sv @@
// Shared types and constants of the piecewise linear branch predictor.
// No dependencies; imported by the address reduction, the datapath, the controller and the top level.
package plbp_pkg;

  localparam int unsigned ADDR_W    = 64;   // branch address width
  localparam int unsigned THR_W     = 12;   // training threshold width
  localparam int unsigned SUM_OUT_W = 13;   // width of the reported sum
  localparam int unsigned WGT_W     = 8;    // weight width
  localparam int unsigned RED_BITS  = 8;    // address bits reduced per cycle
  localparam int unsigned RED_STEPS = ADDR_W / RED_BITS;

  localparam logic [THR_W-1:0] THR_RESET = 12'd57;

  localparam logic signed [WGT_W-1:0] WGT_MAX = 8'sd127;
  localparam logic signed [WGT_W-1:0] WGT_MIN = -8'sd128;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch an accepted beat
    logic red_step;  // one address reduction step
    logic base;      // register row offset, clear the sum
    logic rd_sum;    // read a weight for the sum
    logic rd_train;  // read a weight for training
    logic clr_wr;    // write zero during the clearing pass
    logic finish;    // load the result, shift path and history
  } plbp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic train;     // sum small or mispredicted
    logic out_busy;  // result register full and not taken
  } plbp_stat_t;

endpackage

@@ rtl/plbp_ram.sv @@
// Generic one-write, one-read RAM with registered read data.
// No dependencies.
module plbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2176
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/plbp_mod_red.sv @@
// Reduces a branch address modulo a constant, a byte per cycle while step_i is high, MSB first.
// Depends on plbp_pkg.
module plbp_mod_red
  import plbp_pkg::*;
#(
  parameter int unsigned N = 16
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [ADDR_W-1:0]                   addr_i,
  input  logic                                step_i,
  output logic [((N > 1) ? $clog2(N) : 1)-1:0] rem_o
);

  localparam int unsigned RW = (N > 1) ? $clog2(N) : 1;
  localparam logic [RW:0] N_EXT = (RW+1)'(N);

  logic [ADDR_W-1:0] addr_q;
  logic [RW-1:0]     rem_q;
  logic [RW-1:0]     rem_d;
  logic [RW:0]       t;

  // r = (2r + bit) mod N; r < N keeps t below 2N, so one subtract suffices
  always_comb begin
    rem_d = rem_q;
    t     = '0;
    for (int b = 0; b < RED_BITS; b++) begin
      t = {rem_d, addr_q[ADDR_W-1-b]};
      if (t >= N_EXT) begin
        t = t - N_EXT;
      end
      rem_d = t[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      addr_q <= addr_i;
      rem_q  <= '0;
    end else if (step_i) begin
      addr_q <= {addr_q[ADDR_W-RED_BITS-1:0], RED_BITS'(0)};
      rem_q  <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

@@ rtl/plbp_datapath.sv @@
// Datapath: address reduction, weight RAM, sum, training, path/history, result.
// Depends on plbp_pkg, plbp_ram and plbp_mod_red.
module plbp_datapath
  import plbp_pkg::*;
#(
  parameter int unsigned ROW_COUNT   = 16,
  parameter int unsigned PATH_COUNT  = 8,
  parameter int unsigned HISTORY_LEN = 16,
  parameter int unsigned DEPTH       = 2176,
  parameter int unsigned CNT_W       = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  plbp_cmd_t                   cmd_i,
  input  logic [CNT_W-1:0]            idx_i,
  output plbp_stat_t                  stat_o,
  input  logic [ADDR_W-1:0]           branch_address_i,
  input  logic                        outcome_i,
  input  logic                        cfg_valid_i,
  input  logic [THR_W-1:0]            cfg_data_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        prediction_o,
  output logic signed [SUM_OUT_W-1:0] perceptron_sum_o,
  output logic                        mispredicted_o
);

  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned ROW_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
  localparam int unsigned PATH_W     = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;
  localparam int unsigned POS_W      = $clog2(HISTORY_LEN + 1);
  localparam int unsigned HIST_IW    = $clog2(HISTORY_LEN);
  localparam int unsigned ROW_LEN    = HISTORY_LEN + 1;
  localparam int unsigned ROW_STRIDE = PATH_COUNT * ROW_LEN;
  localparam int unsigned SUM_W      = $clog2(ROW_LEN * 128 + 1) + 1;
  localparam int unsigned EXT_W      = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
  localparam int unsigned CMP_W      = (SUM_W > THR_W) ? SUM_W : THR_W;

  logic [ROW_W-1:0]  row;
  logic [PATH_W-1:0] col;

  plbp_mod_red #(.N(ROW_COUNT)) u_row_red (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .addr_i (branch_address_i),
    .step_i (cmd_i.red_step),
    .rem_o  (row)
  );

  plbp_mod_red #(.N(PATH_COUNT)) u_col_red (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .addr_i (branch_address_i),
    .step_i (cmd_i.red_step),
    .rem_o  (col)
  );

  // state
  logic [HISTORY_LEN-1:0] hist_q;
  logic [PATH_W-1:0]      path_q [HISTORY_LEN];
  logic [THR_W-1:0]       thr_q;
  logic                   acc_pend_q;
  logic                   trn_pend_q;
  logic                   out_valid_q;

  // payload
  logic                    outcome_q;
  logic [AW-1:0]           row_off_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [AW-1:0]           pend_addr_q;
  logic                    pend_dir_q;
  logic                    pred_q;
  logic signed [SUM_OUT_W-1:0] sum_out_q;
  logic                    miss_q;

  // read address of the current position
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_m1;
  logic [HIST_IW-1:0] hidx;
  logic [PATH_W-1:0]  col_sel;
  logic               hist_bit;
  logic               add_dir;
  logic               up_dir;
  logic [AW-1:0]      rd_addr;

  assign pos      = idx_i[POS_W-1:0];
  assign pos_m1   = pos - POS_W'(1);
  assign hidx     = pos_m1[HIST_IW-1:0];
  assign col_sel  = (pos == '0) ? col : path_q[hidx];
  assign hist_bit = hist_q[hidx];
  assign add_dir  = (pos == '0) ? 1'b1 : hist_bit;
  assign up_dir   = (pos == '0) ? outcome_q : (hist_bit == outcome_q);
  assign rd_addr  = row_off_q + AW'(col_sel * ROW_LEN) + AW'(pos);

  // weight RAM
  logic [WGT_W-1:0]        rd_data;
  logic signed [WGT_W-1:0] w;
  logic signed [WGT_W-1:0] w_bump;
  logic signed [SUM_W-1:0] w_ext;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [WGT_W-1:0]        ram_wdata;

  assign w     = $signed(rd_data);
  assign w_ext = SUM_W'(w);

  always_comb begin
    if (pend_dir_q) begin
      w_bump = (w != WGT_MAX) ? w + 8'sd1 : w;
    end else begin
      w_bump = (w != WGT_MIN) ? w - 8'sd1 : w;
    end
  end

  assign ram_we    = cmd_i.clr_wr | trn_pend_q;
  assign ram_waddr = cmd_i.clr_wr ? idx_i[AW-1:0] : pend_addr_q;
  assign ram_wdata = cmd_i.clr_wr ? '0 : $unsigned(w_bump);

  plbp_ram #(.WIDTH(WGT_W), .DEPTH(DEPTH)) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_sum | cmd_i.rd_train),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // decision on the finished sum
  logic                    pred;
  logic                    miss;
  logic [SUM_W-1:0]        mag;
  logic signed [EXT_W-1:0] sum_ext;

  assign pred    = ~sum_q[SUM_W-1];
  assign miss    = pred != outcome_q;
  assign mag     = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
  assign sum_ext = EXT_W'(sum_q);

  assign stat_o.train    = (CMP_W'(mag) < CMP_W'(thr_q)) | miss;
  assign stat_o.out_busy = out_valid_q & ~out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      path_q      <= '{default: '0};
      thr_q       <= THR_RESET;
      acc_pend_q  <= 1'b0;
      trn_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      acc_pend_q <= cmd_i.rd_sum;
      trn_pend_q <= cmd_i.rd_train;
      if (cmd_i.finish) begin
        hist_q <= {hist_q[HISTORY_LEN-2:0], outcome_q};
        for (int i = HISTORY_LEN - 1; i > 0; i--) begin
          path_q[i] <= path_q[i-1];
        end
        path_q[0]   <= col;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      outcome_q <= outcome_i;
    end
    if (cmd_i.base) begin
      row_off_q <= AW'(row * ROW_STRIDE);
      sum_q     <= '0;
    end else if (acc_pend_q) begin
      sum_q <= pend_dir_q ? sum_q + w_ext : sum_q - w_ext;
    end
    if (cmd_i.rd_sum | cmd_i.rd_train) begin
      pend_addr_q <= rd_addr;
      pend_dir_q  <= cmd_i.rd_sum ? add_dir : up_dir;
    end
    if (cmd_i.finish) begin
      pred_q    <= pred;
      sum_out_q <= sum_ext[SUM_OUT_W-1:0];
      miss_q    <= miss;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign prediction_o     = pred_q;
  assign perceptron_sum_o = sum_out_q;
  assign mispredicted_o   = miss_q;

endmodule

@@ rtl/plbp_ctrl.sv @@
// Sequencer: clearing pass, reduction, sum reads, training, result hand-off.
// Depends on plbp_pkg.
module plbp_ctrl
  import plbp_pkg::*;
#(
  parameter int unsigned HISTORY_LEN = 16,
  parameter int unsigned DEPTH       = 2176,
  parameter int unsigned CNT_W       = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  plbp_stat_t       stat_i,
  output plbp_cmd_t        cmd_o,
  output logic [CNT_W-1:0] idx_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_BASE,
    ST_SUM,
    ST_SUM_WAIT,
    ST_JUDGE,
    ST_TRAIN,
    ST_TRAIN_WAIT,
    ST_FINISH
  } state_e;

  localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(HISTORY_LEN);
  localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(RED_STEPS - 1);

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  assign in_ready_o = state_q == ST_IDLE;
  assign idx_o      = cnt_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) & in_valid_i;
    cmd_o.red_step = state_q == ST_REDUCE;
    cmd_o.base     = state_q == ST_BASE;
    cmd_o.rd_sum   = state_q == ST_SUM;
    cmd_o.rd_train = state_q == ST_TRAIN;
    cmd_o.clr_wr   = state_q == ST_CLEAR;
    cmd_o.finish   = (state_q == ST_FINISH) & ~stat_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          if (cnt_q == CLR_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            cnt_q   <= '0;
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (cnt_q == RED_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_BASE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_BASE: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (cnt_q == POS_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_SUM_WAIT;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_SUM_WAIT: begin
          state_q <= ST_JUDGE;
        end
        ST_JUDGE: begin
          state_q <= stat_i.train ? ST_TRAIN : ST_FINISH;
        end
        ST_TRAIN: begin
          if (cnt_q == POS_LAST) begin
            cnt_q   <= '0;
            state_q <= ST_TRAIN_WAIT;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        ST_TRAIN_WAIT: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!stat_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          cnt_q   <= '0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/piecewise_linear_branch_predictor.sv @@
// Piecewise linear branch predictor: one resolved branch per input beat, one result beat out.
// Accept to result valid is set by the serial 8-bit-a-cycle address reduction and the single
// weight RAM read port (H+1 reads, then, only when training, H+1 read-modify-writes); the
// next beat is taken only after the result is loaded. The result register lets the next beat
// in while a result waits.
// Reset: async, active low; a clearing pass writes zero to all DEPTH (2176 by default) weights, in_ready low.
module piecewise_linear_branch_predictor
  import plbp_pkg::*;
#(
  parameter int unsigned ROW_COUNT   = 16,  // weight rows, address mod ROW_COUNT
  parameter int unsigned PATH_COUNT  = 8,   // path columns, address mod PATH_COUNT
  parameter int unsigned HISTORY_LEN = 16   // global history length H
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // branch beats
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ADDR_W-1:0]           branch_address_i,
  input  logic                        outcome_i,
  // result beats
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        prediction_o,
  output logic signed [SUM_OUT_W-1:0] perceptron_sum_o,
  output logic                        mispredicted_o,
  // training threshold write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [THR_W-1:0]            cfg_data_i
);

  // weight store: one bias plus H history weights per (row, column)
  localparam int unsigned DEPTH = ROW_COUNT * PATH_COUNT * (HISTORY_LEN + 1);
  localparam int unsigned AW    = $clog2(DEPTH);
  // one counter serves the clearing sweep, the reduction steps and the positions
  localparam int unsigned CNT_W = (AW > 3) ? AW : 3;

  plbp_cmd_t        cmd;
  plbp_stat_t       stat;
  logic [CNT_W-1:0] idx;

  // threshold register takes a write on any cycle
  assign cfg_ready_o = 1'b1;

  plbp_ctrl #(
    .HISTORY_LEN (HISTORY_LEN),
    .DEPTH       (DEPTH),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  plbp_datapath #(
    .ROW_COUNT   (ROW_COUNT),
    .PATH_COUNT  (PATH_COUNT),
    .HISTORY_LEN (HISTORY_LEN),
    .DEPTH       (DEPTH),
    .CNT_W       (CNT_W)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .idx_i            (idx),
    .stat_o           (stat),
    .branch_address_i (branch_address_i),
    .outcome_i        (outcome_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .prediction_o     (prediction_o),
    .perceptron_sum_o (perceptron_sum_o),
    .mispredicted_o   (mispredicted_o)
  );

endmodule
